// ===== hdl/swss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_pkg
// Shared types and constants of the servo write scheduler with staged
// shutdown.
// ----------------------------------------------------------------------------
package swss_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [7:0] MAX_ANGLE = 8'd180;
    localparam logic [7:0] NO_ANGLE  = 8'hFF;

    // request codes
    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_ESTOP = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_WRITE_DELAY = 2'd0;
    localparam logic [1:0] REG_IDLE_TMO    = 2'd1;
    localparam logic [1:0] REG_POWEROFF    = 2'd2;
    localparam logic [1:0] REG_SUBTRIM     = 2'd3;

    typedef enum logic [1:0] {
        STEP_NONE     = 2'd0,
        STEP_DETACH   = 2'd1,
        STEP_POWER_OFF = 2'd2,
        STEP_DONE     = 2'd3
    } step_t;

    typedef enum logic [2:0] {
        KIND_NOTHING  = 3'd0,
        KIND_WRITE    = 3'd1,
        KIND_DETACH   = 3'd2,
        KIND_POWEROFF = 3'd3,
        KIND_SLEEP    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        WAIT_NONE     = 3'd0,
        WAIT_ZERO     = 3'd1,
        WAIT_WRITE    = 3'd2,
        WAIT_IDLE     = 3'd3,
        WAIT_POWEROFF = 3'd4
    } wait_t;

    typedef struct packed {
        logic  in_load;
        logic  set_wanted;
        logic  clear_wanted;
        logic  detach;
        logic  dec_count;
        wait_t wait_sel;
        logic  run_off;
        logic  step_en;
        step_t step_val;
        logic  scan_clr;
        logic  scan_inc;
        logic  write_ch;
        logic  res_load;
        kind_t res_kind;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       ch_ok;
        logic       no_change;
        logic       running;
        logic       fires;
        step_t      step;
        logic       scan_hit;
        logic       scan_last;
    } sts_t;

endpackage

// ===== hdl/servo_write_scheduler_shutdown.sv =====
`timescale 1ns / 1ps
// result path: a request passes the execute state, then the channel scan when a
// tick expires the countdown in the normal step, then the response state, which
// holds until the output register is free; no new request is taken until then;
// the channel scan goes one channel per cycle through the angle tables
// reset: aresetn low at a clock edge clears angles, attach mask, countdown and
// scheduler; registers return to write_delay 20, idle 1000, power-off 500, trims 0
// ----------------------------------------------------------------------------
// servo_write_scheduler_shutdown
// Servo write scheduler with staged shutdown: request stream in, one result
// per request out, APB configuration port.
// ----------------------------------------------------------------------------
module servo_write_scheduler_shutdown (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // channel[3:0], angle[13:4], no_change[14]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_channel[2:0], out_angle[10:3], attach_first[11]
    output logic [2:0]  m_axis_tuser,   // result_kind[2:0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import swss_pkg::*;

    logic [15:0] write_delay_reg;
    logic [15:0] idle_tmo_reg;
    logic [15:0] poweroff_reg;
    logic [63:0] subtrim_reg;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [2:0]  out_user_reg;

    cmd_t       cmd;
    sts_t       sts;
    logic       out_free;
    logic [2:0] res_kind;
    logic [2:0] res_channel;
    logic [7:0] res_angle;
    logic       res_attach;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_delay_reg <= 16'd20;
            idle_tmo_reg    <= 16'd1000;
            poweroff_reg    <= 16'd500;
            subtrim_reg     <= 64'd0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_WRITE_DELAY: write_delay_reg <= pwdata[15:0];
                REG_IDLE_TMO:    idle_tmo_reg    <= pwdata[15:0];
                REG_POWEROFF:    poweroff_reg    <= pwdata[15:0];
                REG_SUBTRIM:     subtrim_reg     <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_WRITE_DELAY: prdata = {48'd0, write_delay_reg};
            REG_IDLE_TMO:    prdata = {48'd0, idle_tmo_reg};
            REG_POWEROFF:    prdata = {48'd0, poweroff_reg};
            REG_SUBTRIM:     prdata = subtrim_reg;
            default:         prdata = 64'd0;
        endcase
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    swss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    swss_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .in_req           (s_axis_tuser),
        .in_channel       (s_axis_tdata[3:0]),
        .in_angle         (s_axis_tdata[13:4]),
        .in_no_change     (s_axis_tdata[14]),
        .write_delay      (write_delay_reg),
        .idle_timeout     (idle_tmo_reg),
        .poweroff_timeout (poweroff_reg),
        .subtrim_pack     (subtrim_reg),
        .sts              (sts),
        .res_kind         (res_kind),
        .res_channel      (res_channel),
        .res_angle        (res_angle),
        .res_attach       (res_attach)
    );

    // output register: holds a result until the sink takes the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {4'd0, res_attach, res_angle, res_channel};
            out_user_reg <= res_kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result changed before transfer");

    a_write_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_WRITE) |-> (m_axis_tdata[10:3] <= MAX_ANGLE))
        else $error("written angle above limit");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && cmd.out_load))
        else $error("request taken while a result is being loaded");
`endif

endmodule

// ===== hdl/swss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_ctrl
// Controller: takes one request, sequences the channel scan and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module swss_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          out_free,
    input  swss_pkg::sts_t sts,
    output swss_pkg::cmd_t cmd
);
    import swss_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.wait_sel = WAIT_NONE;
        cmd.step_val = STEP_NONE;
        cmd.res_kind = KIND_NOTHING;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next   = ST_RESP;
                cmd.res_load = 1'b1;
                case (sts.req)
                    REQ_SET: begin
                        if (sts.ch_ok) begin
                            if (sts.no_change) begin
                                cmd.clear_wanted = 1'b1;
                            end else begin
                                cmd.set_wanted = 1'b1;
                                cmd.step_en    = 1'b1;
                                cmd.step_val   = STEP_NONE;
                                cmd.wait_sel   = WAIT_ZERO;
                            end
                        end
                    end
                    REQ_TICK: begin
                        if (sts.running) begin
                            cmd.dec_count = 1'b1;
                            if (sts.fires) begin
                                case (sts.step)
                                    STEP_NONE: begin
                                        // no result yet, scan for a changed channel
                                        cmd.res_load = 1'b0;
                                        cmd.scan_clr = 1'b1;
                                        state_next   = ST_SCAN;
                                    end
                                    STEP_DETACH: begin
                                        cmd.detach   = 1'b1;
                                        cmd.wait_sel = WAIT_POWEROFF;
                                        cmd.step_en  = 1'b1;
                                        cmd.step_val = STEP_POWER_OFF;
                                        cmd.res_kind = KIND_DETACH;
                                    end
                                    STEP_POWER_OFF: begin
                                        cmd.run_off  = 1'b1;
                                        cmd.res_kind = KIND_POWEROFF;
                                    end
                                    default: begin
                                        cmd.run_off  = 1'b1;
                                        cmd.res_kind = KIND_SLEEP;
                                    end
                                endcase
                            end
                        end
                    end
                    REQ_ESTOP: begin
                        cmd.detach   = 1'b1;
                        cmd.wait_sel = WAIT_POWEROFF;
                        cmd.step_en  = 1'b1;
                        cmd.step_val = STEP_DETACH;
                        cmd.res_kind = KIND_DETACH;
                    end
                    default: begin
                        cmd.res_kind = KIND_NOTHING;
                    end
                endcase
            end
            ST_SCAN: begin
                if (sts.scan_hit) begin
                    cmd.write_ch = 1'b1;
                    cmd.wait_sel = WAIT_WRITE;
                    cmd.step_en  = 1'b1;
                    cmd.step_val = STEP_NONE;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = KIND_WRITE;
                    state_next   = ST_RESP;
                end else if (sts.scan_last) begin
                    cmd.wait_sel = WAIT_IDLE;
                    cmd.step_en  = 1'b1;
                    cmd.step_val = STEP_DETACH;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = KIND_NOTHING;
                    state_next   = ST_RESP;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transfer not executed");

    a_hit_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && sts.scan_hit) |=> (state_reg == ST_RESP))
        else $error("scan hit did not end the scan");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (state_reg == ST_RESP && out_free))
        else $error("result loaded into a busy output register");
`endif

endmodule

// ===== hdl/swss_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_dp
// Datapath: request registers, per-channel angle tables, attach mask,
// countdown, shutdown step, scan pointer and result register.
// ----------------------------------------------------------------------------
module swss_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  swss_pkg::cmd_t      cmd,
    input  logic [1:0]          in_req,
    input  logic [3:0]          in_channel,
    input  logic signed [9:0]   in_angle,
    input  logic                in_no_change,
    input  logic [15:0]         write_delay,
    input  logic [15:0]         idle_timeout,
    input  logic [15:0]         poweroff_timeout,
    input  logic [63:0]         subtrim_pack,
    output swss_pkg::sts_t      sts,
    output logic [2:0]          res_kind,
    output logic [2:0]          res_channel,
    output logic [7:0]          res_angle,
    output logic                res_attach
);
    import swss_pkg::*;

    // latched request
    logic [1:0]        req_reg;
    logic [3:0]        ch_reg;
    logic signed [9:0] angle_reg;
    logic              nochg_reg;

    // scheduler state
    logic [7:0]          wanted_reg   [CHANNELS];
    logic [7:0]          wanted_next  [CHANNELS];
    logic [7:0]          written_reg  [CHANNELS];
    logic [7:0]          written_next [CHANNELS];
    logic [CHANNELS-1:0] attached_reg, attached_next;
    step_t               step_reg, step_next;
    logic [15:0]         count_reg, count_next;
    logic                running_reg, running_next;
    logic [CH_W-1:0]     idx_reg, idx_next;

    // result
    kind_t      kind_reg;
    logic [2:0] rch_reg;
    logic [7:0] rangle_reg;
    logic       rattach_reg;

    logic [CH_W-1:0]    ch_idx;
    logic               ch_ok;
    logic [7:0]         trim_byte;
    logic signed [10:0] sum;
    logic [7:0]         clamped;
    logic [7:0]         scan_wanted;

    assign ch_idx      = ch_reg[CH_W-1:0];
    assign ch_ok       = (ch_reg < 4'(CHANNELS));
    assign trim_byte   = subtrim_pack[{ch_reg[2:0], 3'b000} +: 8];
    assign sum         = 11'(signed'({angle_reg[9], angle_reg}))
                       + 11'(signed'({{3{trim_byte[7]}}, trim_byte}));
    assign scan_wanted = wanted_reg[idx_reg];

    always_comb begin
        if (sum[10]) begin
            clamped = 8'd0;
        end else if (sum > 11'(MAX_ANGLE)) begin
            clamped = MAX_ANGLE;
        end else begin
            clamped = sum[7:0];
        end
    end

    always_comb begin
        sts.req       = req_reg;
        sts.ch_ok     = ch_ok;
        sts.no_change = nochg_reg;
        sts.running   = running_reg;
        // countdown reaches zero on this tick
        sts.fires     = (count_reg == 16'd0) || (count_reg == 16'd1);
        sts.step      = step_reg;
        sts.scan_hit  = (scan_wanted != NO_ANGLE) && (scan_wanted != written_reg[idx_reg]);
        sts.scan_last = (idx_reg == CH_W'(CHANNELS - 1));
    end

    always_comb begin
        wanted_next   = wanted_reg;
        written_next  = written_reg;
        attached_next = attached_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        running_next  = running_reg;
        idx_next      = idx_reg;

        if (cmd.dec_count && count_reg != 16'd0) begin
            count_next = count_reg - 16'd1;
        end
        if (cmd.set_wanted && ch_ok) begin
            wanted_next[ch_idx] = clamped;
        end
        if (cmd.clear_wanted && ch_ok) begin
            wanted_next[ch_idx] = NO_ANGLE;
        end
        if (cmd.detach) begin
            for (int i = 0; i < CHANNELS; i++) begin
                wanted_next[i]  = NO_ANGLE;
                written_next[i] = NO_ANGLE;
            end
            attached_next = '0;
        end
        if (cmd.write_ch) begin
            written_next[idx_reg]  = scan_wanted;
            attached_next[idx_reg] = 1'b1;
        end
        case (cmd.wait_sel)
            WAIT_ZERO: begin
                count_next   = 16'd0;
                running_next = 1'b1;
            end
            WAIT_WRITE: begin
                count_next   = write_delay;
                running_next = 1'b1;
            end
            WAIT_IDLE: begin
                count_next   = idle_timeout;
                running_next = 1'b1;
            end
            WAIT_POWEROFF: begin
                count_next   = poweroff_timeout;
                running_next = 1'b1;
            end
            default: begin
            end
        endcase
        if (cmd.run_off) begin
            running_next = 1'b0;
        end
        if (cmd.step_en) begin
            step_next = cmd.step_val;
        end
        if (cmd.scan_clr) begin
            idx_next = '0;
        end else if (cmd.scan_inc) begin
            idx_next = idx_reg + CH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                wanted_reg[i]  <= NO_ANGLE;
                written_reg[i] <= NO_ANGLE;
            end
            attached_reg <= '0;
            step_reg     <= STEP_NONE;
            count_reg    <= '0;
            running_reg  <= 1'b0;
            idx_reg      <= '0;
        end else begin
            wanted_reg   <= wanted_next;
            written_reg  <= written_next;
            attached_reg <= attached_next;
            step_reg     <= step_next;
            count_reg    <= count_next;
            running_reg  <= running_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            req_reg   <= in_req;
            ch_reg    <= in_channel;
            angle_reg <= in_angle;
            nochg_reg <= in_no_change;
        end
        if (cmd.res_load) begin
            kind_reg <= cmd.res_kind;
            if (cmd.write_ch) begin
                rch_reg     <= 3'(idx_reg);
                rangle_reg  <= scan_wanted;
                rattach_reg <= ~attached_reg[idx_reg];
            end else begin
                rch_reg     <= 3'd0;
                rangle_reg  <= 8'd0;
                rattach_reg <= 1'b0;
            end
        end
    end

    assign res_kind    = kind_reg;
    assign res_channel = rch_reg;
    assign res_angle   = rangle_reg;
    assign res_attach  = rattach_reg;

endmodule

// ===== sim/servo_write_scheduler_shutdown_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_write_scheduler_shutdown_tb
// Self-checking bench for the servo write scheduler. A directed table walks
// clamping, attach, staged shutdown and emergency stop, then random request
// mixes run under several register settings. Every request transfer yields
// one result transfer, predicted in the bench and compared field by field.
// ----------------------------------------------------------------------------
module servo_write_scheduler_shutdown_tb;
    import swss_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int         STALL_LIMIT = 4000;
    localparam int         PHASES      = 7;
    localparam int         PHASE_ITEMS = 200;
    localparam int         DIR_ROWS    = 26;

    typedef struct packed {
        logic [1:0]        req;
        logic [3:0]        ch;
        logic signed [9:0] angle;
        logic              no_change;
    } servo_req_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] ch;
        logic [7:0] angle;
        logic       attach;
    } servo_res_t;

    typedef struct {
        servo_req_t req;
        bit         typed;
        servo_res_t res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // channel[3:0], angle[13:4], no_change[14]
    logic [1:0]  s_axis_tuser;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // out_channel[2:0], out_angle[10:3], attach_first[11]
    logic [2:0]  m_axis_tuser;   // result_kind[2:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    servo_write_scheduler_shutdown u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // scheduler shadow state
    logic [7:0]  want_deg [CHANNELS];
    logic [7:0]  wrote_deg [CHANNELS];
    logic [7:0]  attach_mask;
    step_t       sched_step;
    logic [15:0] tick_count;
    bit          sched_on;
    logic [15:0] cfg_write_delay;
    logic [15:0] cfg_idle;
    logic [15:0] cfg_poweroff;
    logic [63:0] cfg_trim;

    servo_res_t expected_results [$];
    int         fail_count = 0;
    int         src_gap_max = 17;
    int         snk_gap_max = 17;
    int         quiet_cycles;

    function automatic void drop_all_servos();
        for (int i = 0; i < CHANNELS; i++) begin
            want_deg[i]  = NO_ANGLE;
            wrote_deg[i] = NO_ANGLE;
        end
        attach_mask = '0;
        sched_step  = STEP_DETACH;
    endfunction

    function automatic servo_res_t run_schedule_check();
        servo_res_t res;
        bit         hit;
        res      = '0;
        res.kind = KIND_NOTHING;
        case (sched_step)
            STEP_NONE: begin
                hit = 0;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (!hit && want_deg[i] != NO_ANGLE && want_deg[i] != wrote_deg[i]) begin
                        hit        = 1;
                        res.kind   = KIND_WRITE;
                        res.ch     = 3'(i);
                        res.angle  = want_deg[i];
                        res.attach = !attach_mask[i];
                        attach_mask[i] = 1'b1;
                        wrote_deg[i]   = want_deg[i];
                        tick_count = cfg_write_delay;
                        sched_on   = 1;
                        sched_step = STEP_NONE;
                    end
                end
                if (!hit) begin
                    tick_count = cfg_idle;
                    sched_on   = 1;
                    sched_step = STEP_DETACH;
                end
            end
            STEP_DETACH: begin
                drop_all_servos();
                tick_count = cfg_poweroff;
                sched_on   = 1;
                sched_step = STEP_POWER_OFF;
                res.kind   = KIND_DETACH;
            end
            STEP_POWER_OFF: begin
                sched_on = 0;
                res.kind = KIND_POWEROFF;
            end
            default: begin
                sched_on = 0;
                res.kind = KIND_SLEEP;
            end
        endcase
        return res;
    endfunction

    function automatic servo_res_t predict_servo(servo_req_t r);
        servo_res_t res;
        int         trim;
        int         sum;
        res      = '0;
        res.kind = KIND_NOTHING;
        case (r.req)
            REQ_SET: begin
                if (r.ch < CHANNELS) begin
                    if (r.no_change) begin
                        want_deg[r.ch] = NO_ANGLE;
                    end else begin
                        trim = int'($signed(cfg_trim[8*r.ch +: 8]));
                        sum  = $signed(r.angle) + trim;
                        if (sum < 0) sum = 0;
                        if (sum > int'(MAX_ANGLE)) sum = int'(MAX_ANGLE);
                        want_deg[r.ch] = 8'(sum);
                        sched_step = STEP_NONE;
                        tick_count = '0;
                        sched_on   = 1;
                    end
                end
            end
            REQ_TICK: begin
                if (sched_on) begin
                    if (tick_count != 0) tick_count = tick_count - 1'b1;
                    if (tick_count == 0) res = run_schedule_check();
                end
            end
            REQ_ESTOP: begin
                drop_all_servos();
                tick_count = cfg_poweroff;
                sched_on   = 1;
                res.kind   = KIND_DETACH;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic dir_row_t plain(logic [1:0] rq, int ch, int ang, bit nc);
        dir_row_t row;
        row.req   = '{req: rq, ch: 4'(ch), angle: 10'(ang), no_change: nc};
        row.typed = 0;
        row.res   = '0;
        return row;
    endfunction

    function automatic dir_row_t known(logic [1:0] rq, int ch, int ang, bit nc,
                                       kind_t k, int och, int oang, bit att);
        dir_row_t row;
        row       = plain(rq, ch, ang, nc);
        row.typed = 1;
        row.res   = '{kind: k, ch: 3'(och), angle: 8'(oang), attach: att};
        return row;
    endfunction

    function automatic servo_req_t rand_req(int set_pct);
        servo_req_t r;
        int         pick;
        pick        = $urandom_range(0, 99);
        r.angle     = $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 180));
        r.no_change = ($urandom_range(0, 6) == 0);
        r.ch        = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(CHANNELS, 15))
                                                  : 4'($urandom_range(0, CHANNELS - 1));
        if (pick < 3)                r.req = REQ_ESTOP;
        else if (pick < 5)           r.req = REQ_UNKNOWN;
        else if (pick < 5 + set_pct) r.req = REQ_SET;
        else                         r.req = REQ_TICK;
        return r;
    endfunction

    task automatic send_req(servo_req_t r, bit typed, servo_res_t known_res);
        int         gap;
        servo_res_t pred;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, r.no_change, r.angle, r.ch};
        s_axis_tuser  <= r.req;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pred = predict_servo(r);
        expected_results.push_back(typed ? known_res : pred);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_WRITE_DELAY: cfg_write_delay = value[15:0];
            REG_IDLE_TMO:    cfg_idle        = value[15:0];
            REG_POWEROFF:    cfg_poweroff    = value[15:0];
            default:         cfg_trim        = value;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_regs(logic [15:0] wd, logic [15:0] idle, logic [15:0] poff,
                                logic [63:0] trims);
        write_reg(REG_WRITE_DELAY, {48'd0, wd});
        write_reg(REG_IDLE_TMO, {48'd0, idle});
        write_reg(REG_POWEROFF, {48'd0, poff});
        write_reg(REG_SUBTRIM, trims);
    endtask

    // wait out every pending result, then a margin for the pipeline
    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    initial begin : stimulus
        dir_row_t dir_rows [DIR_ROWS];
        int       set_pct;

        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_SET;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        for (int i = 0; i < CHANNELS; i++) begin
            want_deg[i]  = NO_ANGLE;
            wrote_deg[i] = NO_ANGLE;
        end
        attach_mask     = '0;
        sched_step      = STEP_NONE;
        tick_count      = '0;
        sched_on        = 0;
        cfg_write_delay = 16'd20;
        cfg_idle        = 16'd1000;
        cfg_poweroff    = 16'd500;
        cfg_trim        = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // trims: ch1 +127, ch2 -128, ch3 +10
        program_regs(16'd0, 16'd1, 16'd0, 64'h0000_0000_0A80_7F00);

        dir_rows = '{
            known(REQ_TICK,     0,    0, 0, KIND_NOTHING,  0,   0, 0),
            known(REQ_UNKNOWN,  5,   33, 1, KIND_NOTHING,  0,   0, 0),
            known(REQ_SET,      8,   90, 0, KIND_NOTHING,  0,   0, 0),
            known(REQ_SET,     15,   -1, 1, KIND_NOTHING,  0,   0, 0),
            known(REQ_SET,      0,  511, 0, KIND_NOTHING,  0,   0, 0),
            known(REQ_TICK,     0,    0, 0, KIND_WRITE,    0, 180, 1),
            plain(REQ_SET,      1,  100, 0),
            plain(REQ_SET,      2,  100, 0),
            plain(REQ_SET,      3, -512, 0),
            known(REQ_TICK,     0,    0, 0, KIND_WRITE,    1, 180, 1),
            known(REQ_TICK,     0,    0, 0, KIND_WRITE,    2,   0, 1),
            known(REQ_TICK,     0,    0, 0, KIND_WRITE,    3,   0, 1),
            plain(REQ_SET,      0,   45, 0),
            known(REQ_TICK,     0,    0, 0, KIND_WRITE,    0,  45, 0),
            plain(REQ_SET,      0,    0, 1),
            known(REQ_TICK,     0,    0, 0, KIND_NOTHING,  0,   0, 0),
            known(REQ_TICK,     0,    0, 0, KIND_DETACH,   0,   0, 0),
            known(REQ_TICK,     0,    0, 0, KIND_POWEROFF, 0,   0, 0),
            known(REQ_TICK,     0,    0, 0, KIND_NOTHING,  0,   0, 0),
            plain(REQ_SET,      7,    0, 0),
            known(REQ_ESTOP,    0,    0, 0, KIND_DETACH,   0,   0, 0),
            known(REQ_TICK,     0,    0, 0, KIND_DETACH,   0,   0, 0),
            known(REQ_TICK,     0,    0, 0, KIND_POWEROFF, 0,   0, 0),
            plain(REQ_SET,      6,  179, 0),
            plain(REQ_TICK,     0,    0, 0),
            plain(REQ_TICK,     0,    0, 0)
        };

        foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 64'h8080_8080_8080_8080);
                1: program_regs(16'd0, 16'd0, 16'd0, 64'd0);
                2: program_regs(16'd1, 16'd2, 16'd1, 64'h7F7F_7F7F_7F7F_7F7F);
                default: program_regs(16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)),
                                      16'($urandom_range(0, 5)), {$urandom, $urandom});
            endcase
            set_pct = $urandom_range(15, 45);
            for (int n = 0; n < PHASE_ITEMS; n++) send_req(rand_req(set_pct), 0, '0);
            s_axis_tvalid <= 1'b0;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : result_sink
        int         stall;
        servo_res_t want;
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = $urandom_range(0, snk_gap_max);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected, result_kind %0d", m_axis_tuser);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[2:0] !== want.ch) begin
                    $error("out_channel: expected %0d, actual %0d", want.ch, m_axis_tdata[2:0]);
                    fail_count++;
                end
                if (m_axis_tdata[10:3] !== want.angle) begin
                    $error("out_angle: expected %0d, actual %0d", want.angle,
                           m_axis_tdata[10:3]);
                    fail_count++;
                end
                if (m_axis_tdata[11] !== want.attach) begin
                    $error("attach_first: expected %0d, actual %0d", want.attach,
                           m_axis_tdata[11]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles without a transfer on either stream
    always @(posedge aclk) begin
        if (aresetn !== 1'b1) begin
            quiet_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
